// File: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types and constants for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int CELLS    = COLUMNS * ROWS;
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int CNT_W    = $clog2(CELLS + 1);
    localparam int COL_W    = $clog2(COLUMNS);
    localparam int ROW_W    = $clog2(ROWS);

    // Item field widths
    localparam int OPCODE_W = 2;
    localparam int CHAR_W   = 8;
    localparam int ATTR_W   = 8;
    localparam int RCOL_W   = 7;
    localparam int RROW_W   = 5;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = 16;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_PRINT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

    // Characters and cell values
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'd13;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
    localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h07;
    localparam logic [CELL_W-1:0] BLANK_CELL   = {DEFAULT_ATTR, CH_SPACE};

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [CHAR_W-1:0]   char_code;
        logic [RCOL_W-1:0]   read_column;
        logic [RROW_W-1:0]   read_row;
    } t_in_item;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor_index;
        logic [CELL_W-1:0]   cell_value;
    } t_out_item;

    typedef enum logic [2:0] {
        K_CHAR,
        K_NEWLINE,
        K_CR,
        K_READ,
        K_CLEAR,
        K_NOP
    } t_cmd_kind;

    // Classified command
    typedef struct packed {
        t_cmd_kind          kind;
        logic [CHAR_W-1:0]  char_code;
        logic               in_range;
        logic [ADDR_W-1:0]  read_addr;
    } t_cmd;

    // Queue output toward the back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

endpackage

// File: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Input register: accepts items, decodes them into commands for the queue.
// ----------------------------------------------------------------------------
module tcw_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tcw_pkg::t_in_item i_in,
    output logic              o_in_stall,
    input  logic              i_hold,
    input  logic              i_q_full,
    output logic              o_push,
    output tcw_pkg::t_cmd     o_cmd
);
    import tcw_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  accept;

    assign o_push     = r_valid && !i_q_full;
    assign o_in_stall = i_hold || (r_valid && i_q_full);
    assign accept     = i_in_valid && !o_in_stall;
    assign o_cmd      = r_cmd;

    always_comb begin
        n_cmd.char_code = i_in.char_code;
        n_cmd.in_range  = (int'(i_in.read_column) < COLUMNS) && (int'(i_in.read_row) < ROWS);
        n_cmd.read_addr = n_cmd.in_range ?
                          ADDR_W'(int'(i_in.read_row) * COLUMNS + int'(i_in.read_column)) :
                          '0;
        unique case (i_in.opcode)
            OP_PRINT: begin
                case (i_in.char_code)
                    CH_NEWLINE: n_cmd.kind = K_NEWLINE;
                    CH_CR:      n_cmd.kind = K_CR;
                    default:    n_cmd.kind = K_CHAR;
                endcase
            end
            OP_READ:  n_cmd.kind = K_READ;
            OP_CLEAR: n_cmd.kind = K_CLEAR;
            default:  n_cmd.kind = K_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// File: rtl/tcw_fifo.sv
// ----------------------------------------------------------------------------
// tcw_fifo
// Short command queue between the decode front and the execute back.
// ----------------------------------------------------------------------------
module tcw_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  tcw_pkg::t_cmd    i_cmd,
    output logic             o_full,
    input  logic             i_pop,
    output tcw_pkg::t_q_head o_head
);
    import tcw_pkg::*;

    localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd               r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [COUNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full       = (r_count == COUNT_W'(QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.cmd   = r_slot[r_rd_ptr];
    assign do_push      = i_push && !o_full;
    assign do_pop       = i_pop && o_head.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: rtl/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back
// Execute engine: screen memory, cursor, scroll and clear sweeps, result reg.
// ----------------------------------------------------------------------------
module tcw_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tcw_pkg::t_q_head            i_head,
    output logic                        o_pop,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_attr,
    output logic                        o_hold,
    output logic                        o_out_valid,
    output tcw_pkg::t_out_item          o_out,
    input  logic                        i_out_stall
);
    import tcw_pkg::*;

    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_READ,
        S_SCROLL
    } t_state;

    // Screen memory
    logic [CELL_W-1:0] r_mem [CELLS];
    logic [CELL_W-1:0] r_rd;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;

    // Control
    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_report, n_report;
    logic              r_pend, n_pend;
    logic [ADDR_W-1:0] r_pend_addr, n_pend_addr;
    logic              r_pend_blank, n_pend_blank;
    logic              r_rd_ok, n_rd_ok;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              slot_free;
    logic              produce;
    logic [CELL_W-1:0] res_cell;
    logic              col_last;
    logic              row_last;
    logic [ADDR_W-1:0] cur_addr;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign col_last    = (r_col == COL_W'(COLUMNS - 1));
    assign row_last    = (r_row == ROW_W'(ROWS - 1));
    assign cur_addr    = ADDR_W'(int'(r_row) * COLUMNS + int'(r_col));
    assign o_hold      = (r_state == S_SWEEP) && !r_report;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_report     = r_report;
        n_pend       = 1'b0;
        n_pend_addr  = r_pend_addr;
        n_pend_blank = r_pend_blank;
        n_rd_ok      = r_rd_ok;
        n_col        = r_col;
        n_row        = r_row;
        we           = 1'b0;
        waddr        = '0;
        wdata        = '0;
        raddr        = '0;
        o_pop        = 1'b0;
        produce      = 1'b0;
        res_cell     = '0;

        unique case (r_state)
            S_SWEEP: begin
                we    = 1'b1;
                waddr = r_cnt[ADDR_W-1:0];
                wdata = BLANK_CELL;
                if (r_cnt == CNT_W'(CELLS - 1)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                    produce = r_report;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end

            S_IDLE: begin
                if (i_head.valid && slot_free) begin
                    o_pop = 1'b1;
                    case (i_head.cmd.kind)
                        K_CHAR: begin
                            we    = 1'b1;
                            waddr = cur_addr;
                            wdata = {i_attr, i_head.cmd.char_code};
                            if (col_last) begin
                                n_col = '0;
                                if (row_last) begin
                                    n_state = S_SCROLL;
                                    n_cnt   = '0;
                                end else begin
                                    n_row   = r_row + 1'b1;
                                    produce = 1'b1;
                                end
                            end else begin
                                n_col   = r_col + 1'b1;
                                produce = 1'b1;
                            end
                        end
                        K_NEWLINE: begin
                            if (row_last) begin
                                n_state = S_SCROLL;
                                n_cnt   = '0;
                            end else begin
                                n_row   = r_row + 1'b1;
                                produce = 1'b1;
                            end
                        end
                        K_CR: begin
                            n_col   = '0;
                            produce = 1'b1;
                        end
                        K_READ: begin
                            raddr   = i_head.cmd.read_addr;
                            n_rd_ok = i_head.cmd.in_range;
                            n_state = S_READ;
                        end
                        K_CLEAR: begin
                            n_state  = S_SWEEP;
                            n_cnt    = '0;
                            n_report = 1'b1;
                        end
                        default: begin
                            produce = 1'b1;
                        end
                    endcase
                end
            end

            S_READ: begin
                produce  = 1'b1;
                res_cell = r_rd_ok ? r_rd : '0;
                n_state  = S_IDLE;
            end

            S_SCROLL: begin
                // read one row ahead, write back in the next cycle
                if (r_pend) begin
                    we    = 1'b1;
                    waddr = r_pend_addr;
                    wdata = r_pend_blank ? {r_rd[CELL_W-1:CHAR_W], CH_SPACE} : r_rd;
                end
                if (r_cnt == CNT_W'(CELLS)) begin
                    n_state = S_IDLE;
                    n_cnt   = '0;
                    produce = 1'b1;
                end else begin
                    raddr        = (int'(r_cnt) < CELLS - COLUMNS) ?
                                   ADDR_W'(int'(r_cnt) + COLUMNS) : r_cnt[ADDR_W-1:0];
                    n_pend       = 1'b1;
                    n_pend_addr  = r_cnt[ADDR_W-1:0];
                    n_pend_blank = (int'(r_cnt) >= CELLS - COLUMNS);
                    n_cnt        = r_cnt + 1'b1;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_SWEEP;
            r_cnt       <= '0;
            r_report    <= 1'b0;
            r_pend      <= 1'b0;
            r_col       <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_report <= (n_state == S_SWEEP) ? n_report : 1'b0;
            r_pend   <= n_pend;
            r_col    <= n_col;
            r_row    <= n_row;
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_addr  <= n_pend_addr;
        r_pend_blank <= n_pend_blank;
        r_rd_ok      <= n_rd_ok;
        if (produce) begin
            r_out.cursor_index <= CURSOR_W'(int'(n_row) * COLUMNS + int'(n_col));
            r_out.cell_value   <= res_cell;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[waddr] <= wdata;
        end
        r_rd <= r_mem[raddr];
    end

endmodule

// File: rtl/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console: screen cells, cursor, print / read / clear commands.
// ----------------------------------------------------------------------------
// Path: input register, command queue, execute engine, result register for
//   print, CR, newline and no-op items; reads add S_READ, scroll and clear a sweep.
// Throughput: one item per cycle for prints without scroll while the output is
//   not stalled; a read holds the engine in S_READ for the registered memory read.
// Reset: synchronous, active low. After reset the screen memory is blanked by
//   a sweep over all CELLS cells (2000 at 80x25); input is stalled during it.
// ----------------------------------------------------------------------------
module text_console_writer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // config register (text attribute)
    input  logic                        i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  i_cfg_data,
    // input items
    input  logic                        i_in_valid,
    input  tcw_pkg::t_in_item           i_in,
    output logic                        o_in_stall,
    // result items
    output logic                        o_out_valid,
    output tcw_pkg::t_out_item          o_out,
    input  logic                        i_out_stall
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] r_text_attribute;
    logic              hold;
    logic              q_full;
    logic              push;
    t_cmd              push_cmd;
    t_q_head           q_head;
    logic              pop;

    // Attribute register; the user must write it only while the engine is idle; the block itself does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_attribute <= DEFAULT_ATTR;
        end else if (i_cfg_we) begin
            r_text_attribute <= i_cfg_data;
        end
    end

    // Front: input register and opcode / character decode.
    tcw_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in       (i_in),
        .o_in_stall (o_in_stall),
        .i_hold     (hold),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    // Queue decouples decode from the long scroll / clear sweeps.
    tcw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_head  (q_head)
    );

    // Back: screen memory, cursor, sweeps and the result register.
    tcw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (q_head),
        .o_pop       (pop),
        .i_attr      (r_text_attribute),
        .o_hold      (hold),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text console writer. A table of directed items
// covers reset contents, read bounds, control characters, clear, line wrap
// and both ways into a scroll. Random phases follow, each with its own text
// attribute, mostly lines of text broken by CR/LF with reads, clears and
// no-ops mixed in. Every reply is checked against a shadow of the screen.
// ----------------------------------------------------------------------------
module tb_top;
    import tcw_pkg::*;

    // Opcode 3 has no name in the package; the block treats it as a no-op
    localparam logic [OPCODE_W-1:0] OP_NOP = 2'd3;

    localparam int unsigned ITEMS_PER_PHASE = 290;
    localparam int unsigned PHASES          = 5;
    localparam int unsigned HOLD_AT         = 300;   // items before the long hold-off
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int unsigned TAIL_CYCLES     = 16;
    // Scroll and clear each sweep all CELLS screen cells, and the limit is set so
    // that even every item scrolling stays well inside it
    localparam int unsigned LIMIT_CYCLES    = 20_000_000;

    // ------------------------------------------------------------------------
    // DUT hookup; every input has a known value from time zero
    // ------------------------------------------------------------------------
    logic               i_clk     = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cfg_we    = 1'b0;
    logic [ATTR_W-1:0]  cfg_data  = '0;
    logic               in_valid  = 1'b0;
    t_in_item           in_item   = '0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    t_out_item          out_item;

    text_console_writer_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in        (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out       (out_item),
        .i_out_stall (out_stall)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shadow console: screen, cursor and attribute as the block should hold
    // them, plus the replies still owed by the block, oldest first
    // ------------------------------------------------------------------------
    logic [CELL_W-1:0]  shadow_screen [CELLS];
    int unsigned        shadow_col;
    int unsigned        shadow_row;
    logic [ATTR_W-1:0]  shadow_attr;
    t_out_item          replies_due [$];

    int unsigned        mismatches     = 0;
    int unsigned        items_accepted = 0;

    // Idle shaping shared by sender and receiver
    logic               hold_active  = 1'b0;  // receiver in its long hold-off
    logic               hold_done    = 1'b0;
    logic               no_idle      = 1'b0;  // sender stretch without gaps
    int unsigned        stretch_left = 0;

    function automatic void blank_screen();
        int unsigned i;
        for (i = 0; i < CELLS; i++) shadow_screen[i] = BLANK_CELL;
    endfunction

    // One item through the shadow console; returns the reply it should cause
    function automatic t_out_item console_step(input t_in_item it);
        t_out_item   reply;
        int unsigned pos;
        int unsigned i;
        reply = '0;
        case (it.opcode)
            OP_PRINT: begin
                if (it.char_code == CH_NEWLINE) begin
                    shadow_row++;              // line feed only, column kept
                end else if (it.char_code == CH_CR) begin
                    shadow_col = 0;
                end else begin
                    pos = shadow_row * COLUMNS + shadow_col;
                    if (pos < CELLS) shadow_screen[pos] = {shadow_attr, it.char_code};
                    shadow_col++;
                end
                if (shadow_col >= COLUMNS) begin
                    shadow_col = 0;
                    shadow_row++;
                end
                if (shadow_row >= ROWS) begin
                    // scroll up one row; last row turns to spaces, attributes kept
                    for (i = 0; i + COLUMNS < CELLS; i++)
                        shadow_screen[i] = shadow_screen[i + COLUMNS];
                    for (i = CELLS - COLUMNS; i < CELLS; i++)
                        shadow_screen[i] = {shadow_screen[i][CELL_W-1:CHAR_W], CH_SPACE};
                    shadow_row = ROWS - 1;
                end
            end
            OP_READ: begin
                if (it.read_column < COLUMNS && it.read_row < ROWS)
                    reply.cell_value = shadow_screen[it.read_row * COLUMNS + it.read_column];
            end
            OP_CLEAR: begin
                blank_screen();                // cursor stays put
            end
            default: begin
            end
        endcase
        reply.cursor_index = CURSOR_W'(shadow_row * COLUMNS + shadow_col);
        return reply;
    endfunction

    // Every field random, unused ones included, so all input bits toggle
    function automatic t_in_item random_item();
        logic [31:0]                 word;
        logic [$bits(t_in_item)-1:0] raw;
        word = $urandom;
        raw  = word[$bits(t_in_item)-1:0];
        return raw;
    endfunction

    // Sender gap after an item: mostly short, a few long, none during a
    // no-idle stretch or while the receiver is holding off
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (stretch_left == 0) begin
            stretch_left = $urandom_range(30, 120);
            no_idle      = ($urandom_range(0, 3) == 0);
        end
        stretch_left--;
        if (hold_active || no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    // Offer one item, hold it until accepted, then log the reply it owes.
    // With no gap, valid stays high and the next call puts the next item up
    // at the following falling edge.
    task automatic send_item(input t_in_item it, input logic use_typed,
                             input t_out_item typed_reply);
        t_out_item   predicted;
        int unsigned gap;
        @(negedge i_clk);
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        predicted = console_step(it);
        replies_due.push_back(use_typed ? typed_reply : predicted);
        items_accepted++;
        gap = pick_gap();
        if (gap != 0) begin
            @(negedge i_clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drop valid and let every owed reply arrive
    task automatic drain();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Only called with the block idle
    task automatic set_attribute(input logic [ATTR_W-1:0] attr);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= attr;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        shadow_attr = attr;
    endtask

    // ------------------------------------------------------------------------
    // Directed table. Rows with typed set carry a reply that is plain from
    // the spec; the rest are checked against the shadow. reps repeats a row.
    // ------------------------------------------------------------------------
    typedef struct packed {
        logic [OPCODE_W-1:0] op;
        logic [CHAR_W-1:0]   ch;
        logic [RCOL_W-1:0]   rc;
        logic [RROW_W-1:0]   rr;
        logic [7:0]          reps;
        logic                typed;
        logic [CURSOR_W-1:0] cursor;
        logic [CELL_W-1:0]   cell_val;
    } t_dir_row;

    localparam int DIR_ROWS = 23;

    t_dir_row dir_table [DIR_ROWS] = '{
        // fresh screen: corners read blank, out-of-range reads give zero
        '{OP_READ,  8'h00,      7'd0,   5'd0,  8'd1,  1'b1, 11'd0,    16'h0720},
        '{OP_READ,  8'h00,      7'd79,  5'd24, 8'd1,  1'b1, 11'd0,    16'h0720},
        '{OP_READ,  8'h00,      7'd80,  5'd0,  8'd1,  1'b1, 11'd0,    16'h0000},
        '{OP_READ,  8'h00,      7'd0,   5'd25, 8'd1,  1'b1, 11'd0,    16'h0000},
        '{OP_READ,  8'h00,      7'd127, 5'd31, 8'd1,  1'b1, 11'd0,    16'h0000},
        // printable, byte extremes, CR, LF with column kept, no-op
        '{OP_PRINT, 8'h41,      7'd0,   5'd0,  8'd1,  1'b1, 11'd1,    16'h0000},
        '{OP_READ,  8'h00,      7'd0,   5'd0,  8'd1,  1'b1, 11'd1,    16'h0741},
        '{OP_PRINT, 8'h00,      7'd0,   5'd0,  8'd1,  1'b1, 11'd2,    16'h0000},
        '{OP_PRINT, 8'hFF,      7'd0,   5'd0,  8'd1,  1'b1, 11'd3,    16'h0000},
        '{OP_PRINT, CH_CR,      7'd0,   5'd0,  8'd1,  1'b1, 11'd0,    16'h0000},
        '{OP_PRINT, CH_NEWLINE, 7'd0,   5'd0,  8'd1,  1'b1, 11'd80,   16'h0000},
        '{OP_NOP,   8'hFF,      7'd127, 5'd31, 8'd1,  1'b1, 11'd80,   16'h0000},
        '{OP_READ,  8'h00,      7'd2,   5'd0,  8'd1,  1'b1, 11'd80,   16'h07FF},
        // clear keeps the cursor
        '{OP_CLEAR, 8'h00,      7'd0,   5'd0,  8'd1,  1'b1, 11'd80,   16'h0000},
        '{OP_READ,  8'h00,      7'd2,   5'd0,  8'd1,  1'b1, 11'd80,   16'h0720},
        // walk to the last row, then fill it: wrap off the last cell scrolls
        '{OP_PRINT, CH_NEWLINE, 7'd0,   5'd0,  8'd23, 1'b0, 11'd0,    16'h0000},
        '{OP_PRINT, 8'h5A,      7'd0,   5'd0,  8'd80, 1'b0, 11'd0,    16'h0000},
        '{OP_READ,  8'h00,      7'd79,  5'd23, 8'd1,  1'b1, 11'd1920, 16'h075A},
        '{OP_READ,  8'h00,      7'd0,   5'd24, 8'd1,  1'b1, 11'd1920, 16'h0720},
        // LF on the last row scrolls too, column kept
        '{OP_PRINT, 8'h71,      7'd0,   5'd0,  8'd5,  1'b0, 11'd0,    16'h0000},
        '{OP_PRINT, CH_NEWLINE, 7'd0,   5'd0,  8'd1,  1'b1, 11'd1925, 16'h0000},
        '{OP_READ,  8'h00,      7'd4,   5'd23, 8'd1,  1'b1, 11'd1925, 16'h0771},
        '{OP_PRINT, CH_CR,      7'd0,   5'd0,  8'd1,  1'b1, 11'd1920, 16'h0000}
    };

    // ------------------------------------------------------------------------
    // Reply checker: every accepted reply against the oldest one owed
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item due;
        if (rst_n && out_valid && !out_stall) begin
            if (replies_due.size() == 0) begin
                report_mismatch($sformatf("reply with none owed: cursor %0d cell %h",
                                          out_item.cursor_index, out_item.cell_value));
            end else begin
                due = replies_due.pop_front();
                if (out_item.cursor_index !== due.cursor_index)
                    report_mismatch($sformatf("cursor_index got %0d want %0d",
                                              out_item.cursor_index, due.cursor_index));
                if (out_item.cell_value !== due.cell_value)
                    report_mismatch($sformatf("cell_value got %h want %h",
                                              out_item.cell_value, due.cell_value));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver stall: runs of random length, short and long, stall-free
    // stretches, and one long hold-off once enough items have gone in so
    // the block backs up and stalls its input
    // ------------------------------------------------------------------------
    initial begin : stall_gen
        int unsigned len;
        int unsigned r;
        logic        lvl;
        wait (rst_n);
        forever begin
            if (!hold_done && items_accepted >= HOLD_AT) begin
                hold_active = 1'b1;
                hold_done   = 1'b1;
                lvl         = 1'b1;
                len         = HOLD_CYCLES;
            end else begin
                hold_active = 1'b0;
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    lvl = 1'b0;
                    len = $urandom_range(1, 4);
                end else if (r < 60) begin
                    lvl = 1'b0;
                    len = $urandom_range(20, 120);
                end else if (r < 90) begin
                    lvl = 1'b1;
                    len = $urandom_range(1, 3);
                end else begin
                    lvl = 1'b1;
                    len = $urandom_range(15, 40);
                end
            end
            // one assignment per falling edge
            repeat (len) begin
                @(negedge i_clk);
                out_stall <= lvl;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int unsigned      k;
        int unsigned      phase;
        int unsigned      phase_start;
        int unsigned      pick;
        int unsigned      len;
        int unsigned      tail;
        t_in_item         it;
        t_out_item        typed_reply;
        logic [ATTR_W-1:0] attr;

        blank_screen();
        shadow_col  = 0;
        shadow_row  = 0;
        shadow_attr = DEFAULT_ATTR;

        // Hold reset, then release it; the block then sweeps its screen with
        // the input stalled, which the handshake rides out
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // Directed part, with the attribute still at its reset value
        for (k = 0; k < DIR_ROWS; k++) begin
            it                       = '0;
            it.opcode                = dir_table[k].op;
            it.char_code             = dir_table[k].ch;
            it.read_column           = dir_table[k].rc;
            it.read_row              = dir_table[k].rr;
            typed_reply.cursor_index = dir_table[k].cursor;
            typed_reply.cell_value   = dir_table[k].cell_val;
            repeat (dir_table[k].reps) send_item(it, dir_table[k].typed, typed_reply);
        end

        // Random phases, one attribute each: extremes, random, back to reset
        for (phase = 0; phase < PHASES; phase++) begin
            drain();
            if (phase == 0)      attr = 8'hFF;
            else if (phase == 1) attr = 8'h00;
            else if (phase == 4) attr = DEFAULT_ATTR;
            else                 attr = ATTR_W'($urandom_range(1, 254));
            set_attribute(attr);

            phase_start = items_accepted;
            while (items_accepted - phase_start < ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                it   = random_item();
                if (pick < 25) begin
                    // line of text, mostly printable, usually closed by CR/LF;
                    // long ones wrap
                    len = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 100)
                                                      : $urandom_range(1, 30);
                    repeat (len) begin
                        it        = random_item();
                        it.opcode = OP_PRINT;
                        if ($urandom_range(0, 9) != 0)
                            it.char_code = CHAR_W'($urandom_range(32, 126));
                        send_item(it, 1'b0, '0);
                    end
                    len = $urandom_range(0, 19);
                    if (len < 14) begin
                        it = random_item();
                        it.opcode    = OP_PRINT;
                        it.char_code = CH_CR;
                        send_item(it, 1'b0, '0);
                    end
                    if (len < 17) begin
                        it = random_item();
                        it.opcode    = OP_PRINT;
                        it.char_code = CH_NEWLINE;
                        send_item(it, 1'b0, '0);
                    end
                end else if (pick < 58) begin
                    it.opcode      = OP_READ;
                    it.read_column = RCOL_W'($urandom_range(0, COLUMNS - 1));
                    it.read_row    = RROW_W'($urandom_range(0, ROWS - 1));
                    send_item(it, 1'b0, '0);
                end else if (pick < 66) begin
                    it.opcode = OP_READ;               // any position, bounds too
                    send_item(it, 1'b0, '0);
                end else if (pick < 76) begin
                    it.opcode = OP_PRINT;              // any byte
                    send_item(it, 1'b0, '0);
                end else if (pick < 83) begin
                    it.opcode    = OP_PRINT;
                    it.char_code = CH_NEWLINE;
                    send_item(it, 1'b0, '0);
                end else if (pick < 88) begin
                    it.opcode    = OP_PRINT;
                    it.char_code = CH_CR;
                    send_item(it, 1'b0, '0);
                end else if (pick < 96) begin
                    it.opcode = OP_NOP;
                    send_item(it, 1'b0, '0);
                end else begin
                    it.opcode = OP_CLEAR;
                    send_item(it, 1'b0, '0);
                end
            end
        end

        // Let everything owed come out, then a quiet tail for strays
        drain();
        for (tail = 0; tail < TAIL_CYCLES; tail++) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
